@@ design/lfsc_pkg.sv @@
// Shared types and constants for the LRU frame slot cache.
// No dependencies; imported by the tag store, the top level, the checker and tb_top.
`timescale 1ns / 1ps

package lfsc_pkg;

  localparam int FRAME_W     = 32;
  localparam int SLOT_W      = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = 1 + SLOT_W + 1 + FRAME_W;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [FRAME_W-1:0] evicted_frame;
  } lookup_result_t;

endpackage

@@ design/lru_frame_slot_cache_top.sv @@
// Top level of the LRU frame slot cache: stream handshake, input and result registers.
// Depends on lfsc_pkg and lfsc_tag_store.
//
//   port group   dir  width  contents
//   s_*          in   32     request word: frame_number
//   m_*          out  40     result word: hit, slot, evicted_valid, evicted_frame
//
// A request word is registered on acceptance, looked up and the tag store updated
// once the result register can take it, and the result registered.
// One word per cycle is sustained unless m_tready stalls: the lookup is one compare per
// slot plus the rank update, all between the input register and the result register.
// Reset empties the store (fill count to zero); keys and ranks need no clearing.
// A stalled result holds the lookup stage, which in turn holds the input register.
`timescale 1ns / 1ps

module lru_frame_slot_cache_top
  import lfsc_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] frame_number
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [0] hit, [3:1] slot, [4] evicted_valid,
                                            // [36:5] evicted_frame, [39:37] zero
);

  logic               in_valid;
  logic [FRAME_W-1:0] in_frame;
  logic               out_valid;
  lookup_result_t     out_result;
  lookup_result_t     result;
  logic               advance;
  logic               lookup_en;

  assign advance   = !out_valid || m_tready;
  assign lookup_en = in_valid && advance;
  assign s_tready  = !in_valid || advance;

  lfsc_tag_store #(
    .SLOTS (SLOTS)
  ) u_tag_store (
    .clk          (clk),
    .rst          (rst),
    .lookup_en    (lookup_en),
    .frame_number (in_frame),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (lookup_en) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_frame <= s_tdata[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lookup_en) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_en) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_result.evicted_frame, out_result.evicted_valid,
                     out_result.slot, out_result.hit};

endmodule

@@ design/lfsc_tag_store.sv @@
// Fully associative tag store with per-slot LRU ranks and the lookup logic.
// Depends on lfsc_pkg for the frame width and the result type.
`timescale 1ns / 1ps

module lfsc_tag_store
  import lfsc_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               lookup_en,
  input  logic [FRAME_W-1:0] frame_number,
  output lookup_result_t     result
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // rank 0 is least recently used, fill_count-1 most recently used
  logic [FRAME_W-1:0] keys [SLOTS];
  logic [IDX_W-1:0]   rank [SLOTS];
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   fill_count_next;

  logic [SLOTS-1:0]   valid_vec;
  logic [SLOTS-1:0]   hit_vec;
  logic [SLOTS-1:0]   victim_vec;
  logic               any_hit;
  logic               full;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   hit_rank;
  logic [IDX_W-1:0]   victim_idx;
  logic [FRAME_W-1:0] victim_key;
  logic [IDX_W-1:0]   last_rank;

  always_comb begin
    full       = (fill_count == CNT_W'(SLOTS));
    hit_idx    = '0;
    hit_rank   = '0;
    victim_idx = '0;
    victim_key = '0;
    for (int s = 0; s < SLOTS; s++) begin
      valid_vec[s]  = (CNT_W'(s) < fill_count);
      hit_vec[s]    = valid_vec[s] && (keys[s] == frame_number);
      victim_vec[s] = full && (rank[s] == '0);
      if (hit_vec[s]) begin
        hit_idx  = hit_idx | IDX_W'(s);
        hit_rank = hit_rank | rank[s];
      end
      if (victim_vec[s]) begin
        victim_idx = victim_idx | IDX_W'(s);
        victim_key = victim_key | keys[s];
      end
    end
    any_hit   = |hit_vec;
    last_rank = IDX_W'(fill_count - CNT_W'(1));
  end

  always_comb begin
    result.hit           = any_hit;
    result.evicted_valid = !any_hit && full;
    result.evicted_frame = (!any_hit && full) ? victim_key : '0;
    if (any_hit) begin
      result.slot = SLOT_W'(hit_idx);
    end else if (full) begin
      result.slot = SLOT_W'(victim_idx);
    end else begin
      result.slot = SLOT_W'(fill_count);
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    if (lookup_en && !any_hit && !full) begin
      fill_count_next = fill_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_en) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (any_hit) begin
          // promote the hit slot, close the gap above its old rank
          if (hit_vec[s]) begin
            rank[s] <= last_rank;
          end else if (valid_vec[s] && (rank[s] > hit_rank)) begin
            rank[s] <= rank[s] - IDX_W'(1);
          end
        end else if (!full) begin
          if (CNT_W'(s) == fill_count) begin
            keys[s] <= frame_number;
            rank[s] <= IDX_W'(fill_count);
          end
        end else begin
          // evict the LRU slot and age every other slot by one
          if (victim_vec[s]) begin
            keys[s] <= frame_number;
            rank[s] <= IDX_W'(SLOTS - 1);
          end else begin
            rank[s] <= rank[s] - IDX_W'(1);
          end
        end
      end
    end
  end

  a_victim_unique: assert property (@(posedge clk) disable iff (rst)
    full |-> $onehot(victim_vec))
    else $error("full store must have exactly one LRU slot");

  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    lookup_en |-> $onehot0(hit_vec))
    else $error("frame matched more than one slot");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(SLOTS))
    else $error("fill count beyond slot count");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    lookup_en && !any_hit && !full |=> fill_count == $past(fill_count) + CNT_W'(1))
    else $error("fill miss did not claim a new slot");

endmodule

@@ tb/lfsc_lookup_checker.sv @@
// Checker for the LRU frame slot cache: watches both stream channels, predicts each result.
// Depends on lfsc_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module lfsc_lookup_checker
  import lfsc_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     errors,
  output int                     outstanding
);

  logic [FRAME_W-1:0] held_frame [SLOTS];
  logic [SLOT_W-1:0]  lru_rank   [SLOTS];   // position 0 is least recently used
  int                 slots_used;
  lookup_result_t     pending_results [$];

  initial begin
    errors      = 0;
    outstanding = 0;
    slots_used  = 0;
  end

  task automatic report_mismatch(input string what, input logic [FRAME_W-1:0] got,
                                 input logic [FRAME_W-1:0] want);
    $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Look the frame up, update keys and recency, return the expected result.
  function automatic lookup_result_t lookup_and_touch(input logic [FRAME_W-1:0] frame);
    lookup_result_t    r;
    int                pos;
    logic [SLOT_W-1:0] s;
    r   = '0;
    pos = -1;
    for (int p = 0; p < slots_used; p++)
      if (pos < 0 && held_frame[lru_rank[p]] == frame) pos = p;
    if (pos >= 0) begin
      r.hit  = 1'b1;
      r.slot = lru_rank[pos];
    end else if (slots_used < SLOTS) begin
      // fill the next free slot; it lands at the most recent end already
      s                    = slots_used[SLOT_W-1:0];
      held_frame[s]        = frame;
      lru_rank[slots_used] = s;
      slots_used++;
      r.slot = s;
    end else begin
      pos             = 0;
      s               = lru_rank[0];
      r.slot          = s;
      r.evicted_valid = 1'b1;
      r.evicted_frame = held_frame[s];
      held_frame[s]   = frame;
    end
    if (pos >= 0) begin
      s = lru_rank[pos];
      for (int k = pos; k < slots_used - 1; k++) lru_rank[k] = lru_rank[k + 1];
      lru_rank[slots_used - 1] = s;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      slots_used = 0;
      pending_results.delete();
    end else begin
      // results first: a word leaving now always belongs to an older request
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with no request pending", m_tdata[31:0], '0);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (m_tdata[0] !== want.hit)
            report_mismatch("hit", m_tdata[0], want.hit);
          if (m_tdata[3:1] !== want.slot)
            report_mismatch("slot", m_tdata[3:1], want.slot);
          if (m_tdata[4] !== want.evicted_valid)
            report_mismatch("evicted_valid", m_tdata[4], want.evicted_valid);
          if (m_tdata[36:5] !== want.evicted_frame)
            report_mismatch("evicted_frame", m_tdata[36:5], want.evicted_frame);
          if (m_tdata[39:37] !== 3'b000)
            report_mismatch("pad bits", m_tdata[39:37], '0);
        end
      end
      if (s_tvalid && s_tready)
        pending_results.insert(pending_results.size(),
                               lookup_and_touch(s_tdata[FRAME_W-1:0]));
    end
    outstanding = pending_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for lru_frame_slot_cache_top: clock, reset, request stimulus, verdict.
// Depends on lfsc_pkg, the block and lfsc_lookup_checker.
`timescale 1ns / 1ps

module tb_top;
  import lfsc_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int RANDOM_WORDS = 650;
  localparam int CALM_TAIL    = 100;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int errors;
  int outstanding;
  int words_sent  = 0;
  int quiet_count = 0;
  bit idle_on     = 1'b0;
  bit long_done   = 1'b0;

  always #6 clk = ~clk;

  lru_frame_slot_cache_top #(.SLOTS(8)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lfsc_lookup_checker #(.SLOTS(8)) lookup_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Offer one request word and hold it until accepted.
  task automatic push_frame(input logic [FRAME_W-1:0] frame);
    s_tvalid <= 1'b1;
    s_tdata  <= frame;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic maybe_idle_source();
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Result side: random bursts of back-pressure, plus one long hold-off that lets
  // the block fill up while requests keep coming.
  initial begin : sink
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!long_done && words_sent >= 60) begin
        m_tready  <= 1'b0;
        hold_left = LONG_HOLD - 1;
        long_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        m_tready  <= 1'b0;
        hold_left = $urandom_range(0, 7);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin : stimulus
    logic [FRAME_W-1:0] key_pool [16];
    int                 pool_len;
    int                 pick;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero key into an empty store, then fill, hit LRU/middle,
    // evict a zero key, bring an evicted frame back.
    push_frame(32'h0000_0000);
    push_frame(32'hFFFF_FFFF);
    push_frame(32'h0000_0000);
    push_frame(32'h8000_0000);
    push_frame(32'h5555_5555);
    push_frame(32'hAAAA_AAAA);
    push_frame(32'h0000_0001);
    push_frame(32'h7FFF_FFFF);
    push_frame(32'hFFFF_FFFE);
    push_frame(32'hFFFF_FFFF);
    push_frame(32'hFFFF_FFFE);
    push_frame(32'hAAAA_AAAA);
    push_frame(32'h1234_5678);
    push_frame(32'h0000_0000);
    push_frame(32'h1234_5678);
    push_frame(32'h8000_0000);
    push_frame(32'h5555_5555);
    push_frame(32'h0000_0000);

    // Random: working sets of varying size so hits and evictions both occur.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) begin
        idle_on  = (n < RANDOM_WORDS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
        pool_len = $urandom_range(4, 16);
        for (int i = 0; i < 16; i++)
          key_pool[i] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 31)) : $urandom;
      end
      maybe_idle_source();
      pick = $urandom_range(0, 99);
      if (pick < 70)
        push_frame(key_pool[$urandom_range(0, pool_len - 1)]);
      else if (pick < 85)
        push_frame(key_pool[$urandom_range(0, 3)]);
      else
        push_frame($urandom);
    end
    s_tvalid <= 1'b0;
    idle_on  = 1'b0;

    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
